[src/nfa_pkg.sv]
// shared types and constants for the nfa word acceptor
// no dependencies; imported by nfa_cell and nfa_word_acceptor_core
package nfa_pkg;

    localparam int STATE_W = 4;
    localparam int SYM_W   = 4;
    localparam int MASK_W  = 16;
    localparam int SLOTS   = 16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_BEGIN  = 2'd2,
        OP_SYMBOL = 2'd3
    } opcode_t;

    localparam logic CFG_INITIAL_STATE = 1'b0;
    localparam logic CFG_ACCEPT_MASK   = 1'b1;

    // broadcast from the top level to every cell of the row
    typedef struct packed {
        logic               load;
        logic               add;
        logic               clear;
        logic [STATE_W-1:0] from_state;
        logic [SYM_W-1:0]   symbol;
        logic [STATE_W-1:0] to_state;
        logic [MASK_W-1:0]  next_set;
    } cell_ctrl_t;

endpackage

[src/nfa_cell.sv]
// one state cell: successor masks of its source state, its active bit,
// and one link of the successor-union chain; depends on nfa_pkg
module nfa_cell #(
    parameter int INDEX = 0,
    parameter int SYMS  = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  nfa_pkg::cell_ctrl_t       ctrl,
    input  logic [nfa_pkg::MASK_W-1:0] acc_in,
    output logic [nfa_pkg::MASK_W-1:0] acc_out,
    output logic                      active
);
    import nfa_pkg::*;

    localparam int IDX_W = (SYMS > 1) ? $clog2(SYMS) : 1;

    logic [MASK_W-1:0] mask_reg [SYMS];
    logic [SYMS-1:0]   valid_reg;
    logic [SYMS-1:0]   valid_next;
    logic              active_reg;
    logic              active_next;
    logic [IDX_W-1:0]  sel;
    logic              sym_hit;
    logic              wr;
    logic [MASK_W-1:0] to_bit;
    logic [MASK_W-1:0] entry;

    assign sel     = ctrl.symbol[IDX_W-1:0];
    assign sym_hit = int'(ctrl.symbol) < SYMS;
    assign wr      = ctrl.add && sym_hit && (int'(ctrl.from_state) == INDEX);
    assign to_bit  = MASK_W'(1) << ctrl.to_state;

    // an entry never written since the last clear reads as no successors
    assign entry   = (sym_hit && valid_reg[sel]) ? mask_reg[sel] : '0;
    assign acc_out = acc_in | (active_reg ? entry : '0);
    assign active  = active_reg;

    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = '0;
        end else if (wr) begin
            valid_next[sel] = 1'b1;
        end
    end

    assign active_next = ctrl.load ? ctrl.next_set[INDEX] : active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            active_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mask_reg[sel] <= (valid_reg[sel] ? mask_reg[sel] : '0) | to_bit;
        end
    end

endmodule

[src/nfa_word_acceptor_core.sv]
// top level of the nfa word acceptor: stream ports, configuration
// registers, the row of state cells and the output register; uses nfa_pkg
//
// Programmable NFA recogniser. Each input beat is one command: add a
// transition, clear all transitions, begin a word, or consume a symbol.
// Every beat gives one result beat with the active set after the command
// and an accepted flag. One beat is taken per clock cycle: the next active
// set is the OR of the successor masks of the active states, formed in the
// same cycle as a ripple through the row of state cells (one cell per
// state), and registered in the cells and the output register at the edge
// that takes the beat. The transition store sits in the cells with a valid
// bit per entry, so reset and the clear command take effect at once with no
// clearing pass. The input is held off only while a result waits and the
// output side is stalled.
module nfa_word_acceptor_core #(
    parameter int STATE_COUNT  = 16,
    parameter int SYMBOL_COUNT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    // command input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // opcode, from_state, symbol, to_state, zero pad
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // active_set, accepted, zero pad
);
    import nfa_pkg::*;

    localparam int CELLS = (STATE_COUNT < SLOTS) ? STATE_COUNT : SLOTS;
    localparam int SYMS  = (SYMBOL_COUNT < SLOTS) ? SYMBOL_COUNT : SLOTS;

    logic [STATE_W-1:0] initial_state_reg;
    logic [MASK_W-1:0]  accept_mask_reg;
    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;

    opcode_t            op;
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] to_state;
    logic               accept;
    logic [MASK_W-1:0]  next_set;
    logic [MASK_W-1:0]  active_set;
    logic [MASK_W-1:0]  chain [MASK_W+1];
    cell_ctrl_t         ctrl;

    assign op         = opcode_t'(s_tdata[1:0]);
    assign from_state = s_tdata[5:2];
    assign symbol     = s_tdata[9:6];
    assign to_state   = s_tdata[13:10];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_state_reg <= '0;
            accept_mask_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_INITIAL_STATE: initial_state_reg <= cfg_wdata[STATE_W-1:0];
                CFG_ACCEPT_MASK:   accept_mask_reg   <= cfg_wdata[MASK_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        case (op)
            OP_BEGIN:  next_set = (int'(initial_state_reg) < STATE_COUNT)
                                  ? (MASK_W'(1) << initial_state_reg) : '0;
            OP_SYMBOL: next_set = chain[MASK_W];
            OP_ADD:    next_set = active_set;
            OP_CLEAR:  next_set = active_set;
            default:   next_set = active_set;
        endcase
    end

    always_comb begin
        ctrl.load       = accept;
        ctrl.add        = accept && (op == OP_ADD) && (int'(to_state) < STATE_COUNT);
        ctrl.clear      = accept && (op == OP_CLEAR);
        ctrl.from_state = from_state;
        ctrl.symbol     = symbol;
        ctrl.to_state   = to_state;
        ctrl.next_set   = next_set;
    end

    assign chain[0] = '0;

    // states the parameters leave out get no cell and stay inactive
    for (genvar g = 0; g < MASK_W; g++) begin : g_row
        if (g < CELLS) begin : g_cell
            nfa_cell #(
                .INDEX (g),
                .SYMS  (SYMS)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .acc_in  (chain[g]),
                .acc_out (chain[g+1]),
                .active  (active_set[g])
            );
        end else begin : g_none
            assign chain[g+1]    = chain[g];
            assign active_set[g] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {7'b0, |(next_set & accept_mask_reg), next_set};
        end
    end

endmodule
